// ===== rtl/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg: shared definitions for the filled circle span generator
// Sizes, walk constants and the job record that passes from the front
// classifier through the job queue to the walk and emit engine.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int MAX_DIAMETER = 64;
  localparam int ROW_LIMIT    = 64;

  localparam int DIA_W   = 7;                          // diameter field
  localparam int COORD_W = 6;                          // row and column fields
  localparam int OFF_W   = $clog2(MAX_DIAMETER / 2);   // row offset from center
  localparam int DV_W    = 9;                          // midpoint decision value
  localparam int QDEPTH  = 2;                          // job queue entries

  // Midpoint decision constants
  localparam logic signed [DV_W-1:0] DV_INIT   = 9'sd3;
  localparam logic signed [DV_W-1:0] DV_STEP_E = 9'sd6;
  localparam logic signed [DV_W-1:0] DV_STEP_SE = 9'sd10;

  typedef struct packed {
    logic [COORD_W-1:0] center;
    logic [OFF_W-1:0]   radius;
  } job_t;

endpackage

// ===== rtl/fcs_front.sv =====
// ----------------------------------------------------------------------------
// fcs_front: diameter classifier
// Saturates the diameter, derives center and radius, and pushes the job
// into the queue; stalls the input while the queue is full.
// ----------------------------------------------------------------------------
module fcs_front (
  input  logic                      diameter_valid,
  output logic                      diameter_stall,
  input  logic [fcs_pkg::DIA_W-1:0] diameter,
  input  logic                      queue_full,
  output logic                      push,
  output fcs_pkg::job_t             job
);
  import fcs_pkg::*;

  logic [DIA_W-1:0]   dia_sat;
  logic [COORD_W-1:0] center;
  logic [COORD_W-1:0] radius_raw;
  logic [COORD_W-1:0] radius_clamped;

  always_comb begin
    dia_sat = (diameter > DIA_W'(MAX_DIAMETER)) ? DIA_W'(MAX_DIAMETER) : diameter;
    center  = dia_sat[DIA_W-1:1];
    // small circles collapse to a single pixel
    radius_raw = (center < COORD_W'(2)) ? '0 : center - COORD_W'(2);
    radius_clamped = (radius_raw > COORD_W'(ROW_LIMIT - 1)) ? COORD_W'(ROW_LIMIT - 1)
                                                            : radius_raw;
    job.center = center;
    job.radius = radius_clamped[OFF_W-1:0];
  end

  assign diameter_stall = queue_full;
  assign push           = diameter_valid && !queue_full;

endmodule

// ===== rtl/fcs_queue.sv =====
// ----------------------------------------------------------------------------
// fcs_queue: job queue
// Small FIFO between the classifier and the walk engine so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module fcs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fcs_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          job_valid,
  output fcs_pkg::job_t job
);
  import fcs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QDEPTH));
  assign job_valid = (count != '0);
  assign job       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/fcs_back.sv =====
// ----------------------------------------------------------------------------
// fcs_back: midpoint walk and span emitter
// Walks one octant point per cycle, recording half-widths per row offset in
// two small tables, then reads one row per cycle while the output is not
// stalled, through a read stage and an output register, emitting spans top to bottom.
// ----------------------------------------------------------------------------
module fcs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  fcs_pkg::job_t               job,
  output logic                        job_pop,
  output logic                        span_valid,
  input  logic                        span_stall,
  output logic [fcs_pkg::COORD_W-1:0] row_y,
  output logic [fcs_pkg::COORD_W-1:0] span_left,
  output logic [fcs_pkg::COORD_W-1:0] span_right,
  output logic                        last_span
);
  import fcs_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WALK = 2'd1;
  localparam logic [1:0] PH_EMIT = 2'd2;

  localparam int TAB_DEPTH = MAX_DIAMETER / 2;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [COORD_W+2:0] v);
    if (v < 0) begin
      return '0;
    end else if (v >= (COORD_W+3)'(ROW_LIMIT)) begin
      return COORD_W'(ROW_LIMIT - 1);
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

  // walk and emit control
  logic [1:0]             phase;
  logic [COORD_W-1:0]     center;
  logic [OFF_W-1:0]       radius;
  logic signed [DV_W-1:0] decision_value;
  logic [COORD_W-1:0]     walk_x;
  logic [COORD_W-1:0]     walk_y;
  logic [OFF_W-1:0]       x_last;
  logic [COORD_W-1:0]     emit_row;

  // half-width tables: by walk x (value y) and by walk y (value x)
  logic [OFF_W-1:0] x_table [TAB_DEPTH];
  logic [OFF_W-1:0] y_table [TAB_DEPTH];

  // read stage
  logic               rd_valid;
  logic [COORD_W-1:0] rd_row;
  logic [COORD_W-1:0] rd_center;
  logic               rd_sel_x;
  logic               rd_last;
  logic [OFF_W-1:0]   x_table_q;
  logic [OFF_W-1:0]   y_table_q;

  logic                    table_wr;
  logic                    issue;
  logic                    advance;
  logic                    emit_last;
  logic [COORD_W-1:0]      emit_off_full;
  logic [OFF_W-1:0]        emit_off;
  logic [COORD_W-1:0]      radius_ext;
  logic signed [DV_W-1:0]  step_e;
  logic signed [DV_W-1:0]  step_se;
  logic signed [COORD_W:0] xy_diff;
  logic [OFF_W-1:0]        rd_half;
  logic signed [COORD_W+2:0] row_sum;
  logic signed [COORD_W+2:0] left_sum;
  logic signed [COORD_W+2:0] right_sum;

  assign radius_ext = {{(COORD_W-OFF_W){1'b0}}, radius};
  assign job_pop    = (phase == PH_IDLE) && job_valid;
  assign table_wr   = (phase == PH_WALK) && (walk_x <= walk_y);

  assign xy_diff = $signed({1'b0, walk_x}) - $signed({1'b0, walk_y});
  assign step_e  = $signed({{(DV_W-COORD_W-2){1'b0}}, walk_x, 2'b00}) + DV_STEP_E;
  assign step_se = $signed({xy_diff, 2'b00}) + DV_STEP_SE;

  assign advance   = rd_valid && (!span_valid || !span_stall);
  assign issue     = (phase == PH_EMIT) && (!rd_valid || advance);
  assign emit_last = (emit_row == {radius_ext[COORD_W-2:0], 1'b0});
  assign emit_off_full = (emit_row < radius_ext) ? radius_ext - emit_row
                                                 : emit_row - radius_ext;
  assign emit_off  = emit_off_full[OFF_W-1:0];
  assign row_sum   = $signed({3'b000, center}) - $signed({4'b0000, radius})
                     + $signed({3'b000, emit_row});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      decision_value <= '0;
      walk_x         <= '0;
      walk_y         <= '0;
      emit_row       <= '0;
      x_last         <= '0;
      center         <= '0;
      radius         <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (job_valid) begin
            center         <= job.center;
            radius         <= job.radius;
            walk_x         <= '0;
            walk_y         <= {{(COORD_W-OFF_W){1'b0}}, job.radius};
            decision_value <= DV_INIT - $signed({{(DV_W-OFF_W-1){1'b0}}, job.radius, 1'b0});
            phase          <= PH_WALK;
          end
        end
        PH_WALK: begin
          if (walk_x < walk_y) begin
            if (decision_value < 0) begin
              decision_value <= decision_value + step_e;
            end else begin
              decision_value <= decision_value + step_se;
              walk_y         <= walk_y - 1'b1;
            end
            walk_x <= walk_x + 1'b1;
            x_last <= walk_x[OFF_W-1:0];
          end else begin
            if (walk_x == walk_y) begin
              x_last <= walk_x[OFF_W-1:0];
            end
            emit_row <= '0;
            phase    <= PH_EMIT;
          end
        end
        PH_EMIT: begin
          if (issue) begin
            if (emit_last) begin
              emit_row <= '0;
              phase    <= PH_IDLE;
            end else begin
              emit_row <= emit_row + 1'b1;
            end
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // each walk x is visited once; a later x for the same y is always wider
  always_ff @(posedge clk) begin
    if (table_wr) begin
      x_table[walk_x[OFF_W-1:0]] <= walk_y[OFF_W-1:0];
    end
    if (issue) begin
      x_table_q <= x_table[emit_off];
    end
  end

  always_ff @(posedge clk) begin
    if (table_wr) begin
      y_table[walk_y[OFF_W-1:0]] <= walk_x[OFF_W-1:0];
    end
    if (issue) begin
      y_table_q <= y_table[emit_off];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_row    <= clamp_coord(row_sum);
      rd_center <= center;
      rd_sel_x  <= (emit_off <= x_last);
      rd_last   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (advance) begin
      rd_valid <= 1'b0;
    end
  end

  // offsets touched by walk x hold the widest span; the rest come from walk y
  assign rd_half   = rd_sel_x ? x_table_q : y_table_q;
  assign left_sum  = $signed({3'b000, rd_center}) - $signed({4'b0000, rd_half});
  assign right_sum = $signed({3'b000, rd_center}) + $signed({4'b0000, rd_half});

  always_ff @(posedge clk) begin
    if (advance) begin
      row_y      <= rd_row;
      span_left  <= clamp_coord(left_sum);
      span_right <= clamp_coord(right_sum);
      last_span  <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (advance) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator: filled circle row span generator
// Turns one diameter into the row spans of a filled circle, top to bottom.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (diameter_valid / diameter_stall / diameter): one transaction
//   carries a diameter; values above 64 saturate. A two-entry job queue sits
//   behind the input, so up to two diameters are taken while a circle is
//   still being drawn; diameter_stall rises only when that queue is full.
//   Output channel (span_valid / span_stall / row_y, span_left, span_right,
//   last_span): one transaction per row, inclusive columns, rows ascending,
//   last_span set on the bottom row. A circle of radius r gives 2r+1 spans.
//   Timing: the midpoint walk visits one octant point per cycle; emission
//   then gives one span per cycle while span_stall is low, through a table
//   read stage and an output register. A full-size circle has radius 30;
//   the next circle's job is taken from the queue once the last row read of
//   the current circle has been issued.
//   Stall: span_stall holds the output register and backs up the read stage
//   and emitter; the input keeps filling the queue meanwhile.
//   Reset: rst (synchronous, active high) empties the queue and pipeline.
// ----------------------------------------------------------------------------
module filled_circle_span_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        diameter_valid,
  output logic                        diameter_stall,
  input  logic [fcs_pkg::DIA_W-1:0]   diameter,
  output logic                        span_valid,
  input  logic                        span_stall,
  output logic [fcs_pkg::COORD_W-1:0] row_y,
  output logic [fcs_pkg::COORD_W-1:0] span_left,
  output logic [fcs_pkg::COORD_W-1:0] span_right,
  output logic                        last_span
);
  import fcs_pkg::*;

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t job;

  fcs_front u_front (
    .diameter_valid (diameter_valid),
    .diameter_stall (diameter_stall),
    .diameter       (diameter),
    .queue_full     (queue_full),
    .push           (push),
    .job            (push_job)
  );

  fcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job)
  );

  fcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (pop),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .row_y      (row_y),
    .span_left  (span_left),
    .span_right (span_right),
    .last_span  (last_span)
  );

`ifndef SYNTHESIS
  a_span_ordered: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> (span_left <= span_right))
    else $error("span left end past right end");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> (!diameter_stall && !span_valid))
    else $error("queue or output not empty after reset");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> job_valid)
    else $error("job taken from empty queue");
`endif

endmodule
